FILE: sv/twso_pkg.sv
// Shared types, widths, codes and the time-match helper for the
// time-window switch with override. No dependencies.
`default_nettype none

package twso_pkg;

   // Field widths
   localparam int OP_W      = 2;
   localparam int HOUR_W    = 5;
   localparam int MIN_W     = 6;
   localparam int SEC_W     = 6;
   localparam int MINUTES_W = 10;
   localparam int CNT_W     = 16;

   // Scheme constants
   localparam int NUM_WINDOWS            = 5;
   localparam int TICKS_PER_MINUTE       = 60;
   localparam int SEC_TOLERANCE          = 5;
   localparam int MAX_OVERRIDE_MINUTES   = 999;
   localparam int MIN_OVERRIDE_MINUTES   = 1;
   localparam int RESET_OVERRIDE_MINUTES = 30;

   // Override limit in ticks, sized for the largest legal length
   localparam int LIMIT_W = $clog2(MAX_OVERRIDE_MINUTES * TICKS_PER_MINUTE + 1);
   localparam int CMP_W   = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
   localparam logic [CNT_W-1:0] COUNTER_MAX = {CNT_W{1'b1}};

   // Register map
   localparam int NUM_REGS    = NUM_WINDOWS + 1;
   localparam int CSR_INDEX_W = $clog2(NUM_REGS);
   localparam int CSR_DATA_W  = 34;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_A         = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_OVERRIDE_MINUTES = CSR_INDEX_W'(NUM_WINDOWS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK       = 2'd0;
   localparam logic [OP_W-1:0] OP_MANUAL_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_MANUAL_ON  = 2'd2;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } time_type;

   // Packing matches the window registers: start in the upper half
   typedef struct packed {
      time_type start;
      time_type stop;
   } window_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      time_type        now;
   } req_type;

   typedef struct packed {
      logic switch_on;
      logic override_active;
      logic override_expired;
      logic scheduled_start;
      logic scheduled_stop;
   } rsp_type;

   typedef struct packed {
      logic             switch_on;
      logic             override_active;
      logic [CNT_W-1:0] seconds_counted;
   } state_type;

   typedef struct {
      window_type         windows [NUM_WINDOWS];
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   // Same hour and minute, seconds within the tolerance, no minute wrap
   function automatic logic time_match(time_type win, time_type now);
      logic [SEC_W-1:0] diff;
      diff = (win.second > now.second) ? (win.second - now.second)
                                       : (now.second - win.second);
      return (win.hour == now.hour) && (win.minute == now.minute) &&
             (diff <= SEC_W'(SEC_TOLERANCE));
   endfunction

endpackage

`default_nettype wire

FILE: sv/twso_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on twso_pkg for field widths.
`default_nettype none

interface twso_req_if;
   logic                          valid;
   logic                          ready;
   logic [twso_pkg::OP_W-1:0]     operation;
   logic [twso_pkg::HOUR_W-1:0]   now_hour;
   logic [twso_pkg::MIN_W-1:0]    now_minute;
   logic [twso_pkg::SEC_W-1:0]    now_second;

   modport source (output valid, operation, now_hour, now_minute, now_second,
                   input ready);
   modport sink   (input valid, operation, now_hour, now_minute, now_second,
                   output ready);
endinterface

interface twso_rsp_if;
   logic valid;
   logic ready;
   logic switch_on;
   logic override_active;
   logic override_expired;
   logic scheduled_start;
   logic scheduled_stop;

   modport source (output valid, switch_on, override_active, override_expired,
                   scheduled_start, scheduled_stop, input ready);
   modport sink   (input valid, switch_on, override_active, override_expired,
                   scheduled_start, scheduled_stop, output ready);
endinterface

`default_nettype wire

FILE: sv/twso_csr.sv
// Configuration registers: five window times and the override limit,
// kept as a tick count. Depends on twso_pkg.
`default_nettype none

module twso_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [twso_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [twso_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output twso_pkg::cfg_type                        cfg
);

   twso_pkg::window_type                  windows_ff [twso_pkg::NUM_WINDOWS];
   logic [twso_pkg::LIMIT_W-1:0]          limit_ff;
   logic [twso_pkg::MINUTES_W-1:0]        minutes;
   logic                                  minutes_ok;

   // Out-of-range lengths are dropped
   assign minutes    = csr_wdata[twso_pkg::MINUTES_W-1:0];
   assign minutes_ok = (minutes >= twso_pkg::MINUTES_W'(twso_pkg::MIN_OVERRIDE_MINUTES)) &&
                       (minutes <= twso_pkg::MINUTES_W'(twso_pkg::MAX_OVERRIDE_MINUTES));

   // Window registers
   for (genvar i = 0; i < twso_pkg::NUM_WINDOWS; i++) begin : g_win
      always_ff @(posedge clock) begin
         if (reset) begin
            windows_ff[i] <= '0;
         end else if (csr_we &&
                      csr_index == twso_pkg::REG_WINDOW_A + twso_pkg::CSR_INDEX_W'(i)) begin
            windows_ff[i] <= csr_wdata;
         end
      end
      assign cfg.windows[i] = windows_ff[i];
   end

   // Override limit, stored already scaled to ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= twso_pkg::LIMIT_W'(twso_pkg::RESET_OVERRIDE_MINUTES *
                                        twso_pkg::TICKS_PER_MINUTE);
      end else if (csr_we && csr_index == twso_pkg::REG_OVERRIDE_MINUTES && minutes_ok) begin
         limit_ff <= twso_pkg::LIMIT_W'(minutes) *
                     twso_pkg::LIMIT_W'(twso_pkg::TICKS_PER_MINUTE);
      end
   end

   assign cfg.limit = limit_ff;

endmodule

`default_nettype wire

FILE: sv/twso_step.sv
// Next-state and response logic for one item: manual on and off, override
// timeout and the ordered window scan. Combinational. Depends on twso_pkg.
`default_nettype none

module twso_step (
   input  wire twso_pkg::req_type    item,
   input  wire twso_pkg::state_type  state,
   input  wire twso_pkg::cfg_type    cfg,
   output twso_pkg::state_type       state_in,
   output twso_pkg::rsp_type         rsp
);

   logic [twso_pkg::NUM_WINDOWS-1:0] start_hit;
   logic [twso_pkg::NUM_WINDOWS-1:0] stop_hit;

   // All ten comparisons run side by side
   always_comb begin
      for (int i = 0; i < twso_pkg::NUM_WINDOWS; i++) begin
         start_hit[i] = twso_pkg::time_match(cfg.windows[i].start, item.now);
         stop_hit[i]  = twso_pkg::time_match(cfg.windows[i].stop, item.now);
      end
   end

   always_comb begin
      logic [twso_pkg::CNT_W-1:0] cnt;
      logic sw;
      logic ov;
      logic expired;
      logic started;
      logic stopped;

      cnt     = state.seconds_counted;
      sw      = state.switch_on;
      ov      = state.override_active;
      expired = 1'b0;
      started = 1'b0;
      stopped = 1'b0;

      unique case (item.operation)
         twso_pkg::OP_MANUAL_ON: begin
            sw  = 1'b1;
            ov  = 1'b1;
            cnt = '0;
         end
         twso_pkg::OP_MANUAL_OFF: begin
            sw = 1'b0;
            ov = 1'b0;
         end
         twso_pkg::OP_TICK: begin
            // saturating second counter
            if (cnt != twso_pkg::COUNTER_MAX) begin
               cnt = cnt + 1'b1;
            end
            if (ov && (twso_pkg::CMP_W'(cnt) >= twso_pkg::CMP_W'(cfg.limit))) begin
               sw      = 1'b0;
               ov      = 1'b0;
               expired = 1'b1;
            end
            // windows in order, start before stop; last change wins
            if (!ov) begin
               for (int i = 0; i < twso_pkg::NUM_WINDOWS; i++) begin
                  if (start_hit[i] && !sw) begin
                     sw      = 1'b1;
                     started = 1'b1;
                  end
                  if (stop_hit[i] && sw) begin
                     sw      = 1'b0;
                     stopped = 1'b1;
                  end
               end
            end
         end
         default: begin
            // unused code: state holds, no events
         end
      endcase

      state_in.switch_on       = sw;
      state_in.override_active = ov;
      state_in.seconds_counted = cnt;
      rsp.switch_on            = sw;
      rsp.override_active      = ov;
      rsp.override_expired     = expired;
      rsp.scheduled_start      = started;
      rsp.scheduled_stop       = stopped;
   end

endmodule

`default_nettype wire

FILE: sv/time_window_switch_with_override_core.sv
// Top level of the time-window switch with override: input register,
// step logic, state and response register. Depends on twso_pkg, twso_ifs,
// twso_csr and twso_step.
//
// Usage:
//  - req_ch carries one item per transfer: a one-second tick with the time
//    of day, a manual on or a manual off. rsp_ch returns exactly one result
//    per item, in order: switch state, override state and event flags.
//  - csr_we/csr_index/csr_wdata write the five windows (index 0..4) and the
//    override length in minutes (index 5); write only while no item is in
//    flight. Lengths of 0 or above 999 are ignored.
//  - Each request is held in the input register until the result register
//    is free, then its result is loaded there and rsp_ch.valid rises.
//  - Throughput: one item per cycle while results are taken. The switch
//    state feeds back through one register, updated in the same cycle the
//    item reaches the result register.
//  - A stalled receiver holds the result register; the input register
//    still takes one more item, then req_ch.ready drops until the result
//    is taken.
//  - Synchronous reset clears both pipeline stages, turns the switch off,
//    ends any override, zeroes the tick counter and restores the register
//    defaults (windows 0, override 30 minutes).
`default_nettype none

module time_window_switch_with_override_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   twso_req_if.sink                               req_ch,
   twso_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [twso_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [twso_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   twso_pkg::cfg_type    cfg;
   twso_pkg::req_type    item_ff;
   logic                 item_valid_ff;
   twso_pkg::state_type  state_ff;
   twso_pkg::state_type  state_in;
   twso_pkg::rsp_type    rsp_ff;
   twso_pkg::rsp_type    rsp_in;
   logic                 rsp_valid_ff;
   logic                 advance;
   logic                 req_xfer;

   twso_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   twso_step u_step (
      .item     (item_ff),
      .state    (state_ff),
      .cfg      (cfg),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   // Pipeline moves when the result register is free or being emptied
   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.operation   <= req_ch.operation;
         item_ff.now.hour    <= req_ch.now_hour;
         item_ff.now.minute  <= req_ch.now_minute;
         item_ff.now.second  <= req_ch.now_second;
      end
   end

   // Switch state, updated as each item retires into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.switch_on        = rsp_ff.switch_on;
   assign rsp_ch.override_active  = rsp_ff.override_active;
   assign rsp_ch.override_expired = rsp_ff.override_expired;
   assign rsp_ch.scheduled_start  = rsp_ff.scheduled_start;
   assign rsp_ch.scheduled_stop   = rsp_ff.scheduled_stop;

endmodule

`default_nettype wire

FILE: sv/twso_checker.sv
// Port-level checks for the time-window switch core, bound to the top
// level. Depends on the top level's port list.
`default_nettype none

module twso_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic switch_on,
   input wire logic override_active,
   input wire logic override_expired,
   input wire logic scheduled_start,
   input wire logic scheduled_stop
);

   // Nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({switch_on, override_active,
         override_expired, scheduled_start, scheduled_stop}))
      else $error("stalled response changed");

   // An override always drives the switch on
   a_override_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && override_active |-> switch_on)
      else $error("override active with switch off");

   // Timeout and window events only happen with no override left
   a_events_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (override_expired || scheduled_start || scheduled_stop)
      |-> !override_active)
      else $error("event flag raised while override holds");

   // A lone stop leaves the switch off
   a_stop_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && scheduled_stop && !scheduled_start |-> !switch_on)
      else $error("scheduled stop left switch on");

endmodule

bind time_window_switch_with_override_core twso_checker u_twso_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .switch_on        (rsp_ch.switch_on),
   .override_active  (rsp_ch.override_active),
   .override_expired (rsp_ch.override_expired),
   .scheduled_start  (rsp_ch.scheduled_start),
   .scheduled_stop   (rsp_ch.scheduled_stop)
);

`default_nettype wire
